// ===== rtl/core/met_pkg.sv =====
`timescale 1ns / 1ps

package met_pkg;

	localparam int COLUMN_W    = 12;
	localparam int ROW_W       = 12;
	localparam int DIM_W       = 13;
	localparam int ITER_W      = 16;
	localparam int INTENSITY_W = 8;
	localparam int SCALE_W     = 63;
	localparam int FIX_W       = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	typedef logic signed [FIX_W-1:0] met_fix_t;

	localparam met_fix_t FIX_MIN = {1'b1, {(FIX_W-1){1'b0}}};
	localparam met_fix_t FIX_MAX = {1'b0, {(FIX_W-1){1'b1}}};

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_SCALE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_REAL    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_IMAG    = 3'd5;

	localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH    = 13'd100;
	localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT   = 13'd100;
	localparam logic [ITER_W-1:0]  RST_MAX_ITERATIONS = 16'd500;
	localparam logic [SCALE_W-1:0] RST_PIXEL_SCALE    = 63'd7205759403792794;
	localparam met_fix_t           RST_CENTER_REAL    = -64'sd94768777294422063;
	localparam met_fix_t           RST_CENTER_IMAG    = 64'sd5294910904706945;

	// multiplier operand selection
	typedef enum logic [2:0] {
		MOP_MAP_RE,
		MOP_MAP_IM,
		MOP_RR,
		MOP_II,
		MOP_RI
	} met_mop_t;

	// right shift applied to the full product
	typedef enum logic [1:0] {
		SH_ONE,
		SH_FRAC,
		SH_FRAC_M1
	} met_shift_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		met_mop_t mul_op;
		logic     wr_cr;
		logic     wr_ci;
		logic     wr_rr;
		logic     wr_ii;
		logic     wr_z;
		logic     div_start;
		logic     out_load;
	} met_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic cnt_lim;
		logic esc;
	} met_status_t;

	function automatic met_fix_t sat_add(input met_fix_t a, input met_fix_t b);
		logic signed [FIX_W:0] s;
		s = {a[FIX_W-1], a} + {b[FIX_W-1], b};
		if (s[FIX_W] != s[FIX_W-1]) begin
			sat_add = s[FIX_W] ? FIX_MIN : FIX_MAX;
		end else begin
			sat_add = s[FIX_W-1:0];
		end
	endfunction

	function automatic met_fix_t sat_sub(input met_fix_t a, input met_fix_t b);
		logic signed [FIX_W:0] s;
		s = {a[FIX_W-1], a} - {b[FIX_W-1], b};
		if (s[FIX_W] != s[FIX_W-1]) begin
			sat_sub = s[FIX_W] ? FIX_MIN : FIX_MAX;
		end else begin
			sat_sub = s[FIX_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/met_pixel_if.sv =====
`timescale 1ns / 1ps

interface met_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [met_pkg::COLUMN_W-1:0]  column;
	logic [met_pkg::ROW_W-1:0]     row_index;

	modport source (output valid, output column, output row_index, input ready);
	modport sink (input valid, input column, input row_index, output ready);
endinterface

// ===== rtl/core/met_result_if.sv =====
`timescale 1ns / 1ps

interface met_result_if;
	logic                            valid;
	logic                            ready;
	logic [met_pkg::INTENSITY_W-1:0] intensity;
	logic [met_pkg::ITER_W-1:0]      iteration_count;

	modport source (output valid, output intensity, output iteration_count, input ready);
	modport sink (input valid, input intensity, input iteration_count, output ready);
endinterface

// ===== rtl/core/met_mul.sv =====
`timescale 1ns / 1ps

// Signed 64x64 multiply on one 32x32 unit, four partial products,
// then sign fix, arithmetic shift and saturation to 64 bits.
module met_mul #(
	parameter int unsigned FRAC_BITS = 56
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  met_pkg::met_fix_t    a,
	input  met_pkg::met_fix_t    b,
	input  met_pkg::met_shift_t  shift_sel,
	output logic                 done,
	output met_pkg::met_fix_t    res
);

	localparam logic [2:0] PH_LAST_PP = 3'd3;
	localparam logic [2:0] PH_FINAL   = 3'd5;

	logic [63:0]          ua_q, ub_q;
	logic                 neg_q;
	met_pkg::met_shift_t  sh_q;
	logic                 busy_q;
	logic [2:0]           phase_q;
	logic [63:0]          pp_s1;
	logic [1:0]           pp_off_s1;
	logic                 pp_vld_s1;
	logic [127:0]         acc_q;
	logic                 done_q;
	met_pkg::met_fix_t    res_q;

	logic [63:0]          ua_d, ub_d;
	logic [31:0]          op_a, op_b;
	logic [1:0]           off_d;
	logic [63:0]          pp_d;
	logic [127:0]         addend;
	logic signed [127:0]  fin_v, fin_sh;
	met_pkg::met_fix_t    fin_res;

	assign ua_d = a[63] ? (~a + 64'd1) : a;
	assign ub_d = b[63] ? (~b + 64'd1) : b;

	always_comb begin
		case (phase_q[1:0])
			2'd0: begin
				op_a = ua_q[31:0];  op_b = ub_q[31:0];  off_d = 2'd0;
			end
			2'd1: begin
				op_a = ua_q[31:0];  op_b = ub_q[63:32]; off_d = 2'd1;
			end
			2'd2: begin
				op_a = ua_q[63:32]; op_b = ub_q[31:0];  off_d = 2'd1;
			end
			default: begin
				op_a = ua_q[63:32]; op_b = ub_q[63:32]; off_d = 2'd2;
			end
		endcase
	end

	assign pp_d = op_a * op_b;

	always_comb begin
		case (pp_off_s1)
			2'd0:    addend = {64'd0, pp_s1};
			2'd1:    addend = {32'd0, pp_s1, 32'd0};
			default: addend = {pp_s1, 64'd0};
		endcase
	end

	always_comb begin
		fin_v = neg_q ? (~acc_q + 128'd1) : acc_q;
		case (sh_q)
			met_pkg::SH_ONE:     fin_sh = fin_v >>> 1;
			met_pkg::SH_FRAC:    fin_sh = fin_v >>> FRAC_BITS;
			met_pkg::SH_FRAC_M1: fin_sh = fin_v >>> (FRAC_BITS - 1);
			default:             fin_sh = fin_v >>> FRAC_BITS;
		endcase
		if ((&fin_sh[127:63]) || !(|fin_sh[127:63])) begin
			fin_res = fin_sh[63:0];
		end else begin
			fin_res = fin_sh[127] ? met_pkg::FIX_MIN : met_pkg::FIX_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			phase_q   <= 3'd0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			pp_vld_s1 <= busy_q && (phase_q <= PH_LAST_PP);
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 3'd0;
			end else if (busy_q) begin
				if (phase_q == PH_FINAL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					phase_q <= phase_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= ua_d;
			ub_q  <= ub_d;
			neg_q <= a[63] ^ b[63];
			sh_q  <= shift_sel;
			acc_q <= 128'd0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + addend;
		end
		pp_s1     <= pp_d;
		pp_off_s1 <= off_d;
		if (busy_q && phase_q == PH_FINAL) begin
			res_q <= fin_res;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== rtl/core/met_div.sv =====
`timescale 1ns / 1ps

// Restoring divide, one quotient bit per cycle. Needs num < den * 256.
module met_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [met_pkg::ITER_W+7:0]         num,
	input  logic [met_pkg::ITER_W-1:0]         den,
	output logic                               done,
	output logic [met_pkg::INTENSITY_W-1:0]    quo
);

	localparam int NW = met_pkg::ITER_W + 8;

	logic [NW-1:0]                     r_q;
	logic [NW-1:0]                     d_q;
	logic [met_pkg::INTENSITY_W-1:0]   q_q;
	logic [2:0]                        step_q;
	logic                              busy_q;
	logic                              done_q;
	logic                              ge;

	assign ge = (r_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num;
			d_q <= {1'b0, den, 7'd0};
		end else if (busy_q) begin
			if (ge) begin
				r_q <= r_q - d_q;
			end
			d_q <= d_q >> 1;
			q_q <= {q_q[met_pkg::INTENSITY_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ===== rtl/core/met_datapath.sv =====
`timescale 1ns / 1ps

module met_datapath #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned FRAC_BITS = 56
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [met_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic [met_pkg::COLUMN_W-1:0]          column,
	input  logic [met_pkg::ROW_W-1:0]             row_index,
	input  met_pkg::met_cmd_t                     cmd,
	output met_pkg::met_status_t                  status,
	output logic [met_pkg::INTENSITY_W-1:0]       intensity,
	output logic [met_pkg::ITER_W-1:0]            iteration_count
);

	localparam int IDX_W = 17;
	localparam logic [IDX_W-1:0] IDX_LIM = IDX_W'(MAX_DIM - 1);
	localparam met_pkg::met_fix_t FOUR = 64'sd1 <<< (FRAC_BITS + 2);

	// configuration
	logic [met_pkg::DIM_W-1:0]    width_q, height_q;
	logic [met_pkg::ITER_W-1:0]   max_q;
	logic [met_pkg::SCALE_W-1:0]  scale_q;
	met_pkg::met_fix_t            cre_q, cim_q;

	// per-pixel working set
	logic [met_pkg::COLUMN_W-1:0] col_q;
	logic [met_pkg::ROW_W-1:0]    row_q;
	met_pkg::met_fix_t            cr_q, ci_q, zr_q, zi_q, rr_q, diff_q;
	logic                         esc_q;
	logic [met_pkg::ITER_W-1:0]   count_q;
	logic [met_pkg::INTENSITY_W-1:0] intensity_q;
	logic [met_pkg::ITER_W-1:0]   iter_out_q;

	met_pkg::met_fix_t            off_re, off_im;
	met_pkg::met_fix_t            mul_a, mul_b, mres;
	met_pkg::met_shift_t          mul_sh;
	logic                         mul_done, div_done;
	logic [met_pkg::ITER_W+7:0]   div_num;
	logic [met_pkg::INTENSITY_W-1:0] div_quo;

	// 2*min(idx, MAX_DIM-1) - dim, sign-extended
	function automatic met_pkg::met_fix_t map_off(input logic [11:0] idx,
		input logic [met_pkg::DIM_W-1:0] dim);
		logic [IDX_W-1:0]  idx_c;
		logic signed [18:0] off;
		idx_c = ({5'd0, idx} > IDX_LIM) ? IDX_LIM : {5'd0, idx};
		off = $signed({1'b0, idx_c, 1'b0}) - $signed({6'd0, dim});
		map_off = {{45{off[18]}}, off};
	endfunction

	assign off_re = map_off(col_q, width_q);
	assign off_im = map_off(row_q, height_q);

	always_comb begin
		case (cmd.mul_op)
			met_pkg::MOP_MAP_RE: begin
				mul_a = off_re; mul_b = {1'b0, scale_q}; mul_sh = met_pkg::SH_ONE;
			end
			met_pkg::MOP_MAP_IM: begin
				mul_a = off_im; mul_b = {1'b0, scale_q}; mul_sh = met_pkg::SH_ONE;
			end
			met_pkg::MOP_RR: begin
				mul_a = zr_q; mul_b = zr_q; mul_sh = met_pkg::SH_FRAC;
			end
			met_pkg::MOP_II: begin
				mul_a = zi_q; mul_b = zi_q; mul_sh = met_pkg::SH_FRAC;
			end
			met_pkg::MOP_RI: begin
				mul_a = zr_q; mul_b = zi_q; mul_sh = met_pkg::SH_FRAC_M1;
			end
			default: begin
				mul_a = zr_q; mul_b = zr_q; mul_sh = met_pkg::SH_FRAC;
			end
		endcase
	end

	met_mul #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mul_start),
		.a         (mul_a),
		.b         (mul_b),
		.shift_sel (mul_sh),
		.done      (mul_done),
		.res       (mres)
	);

	// 255 * count
	assign div_num = {count_q, 8'd0} - {8'd0, count_q};

	met_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (max_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= met_pkg::RST_IMAGE_WIDTH;
			height_q <= met_pkg::RST_IMAGE_HEIGHT;
			max_q    <= met_pkg::RST_MAX_ITERATIONS;
			scale_q  <= met_pkg::RST_PIXEL_SCALE;
			cre_q    <= met_pkg::RST_CENTER_REAL;
			cim_q    <= met_pkg::RST_CENTER_IMAG;
		end else if (cfg_we) begin
			case (cfg_index)
				met_pkg::CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata[met_pkg::DIM_W-1:0];
				met_pkg::CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata[met_pkg::DIM_W-1:0];
				met_pkg::CFG_MAX_ITERATIONS: max_q    <= cfg_wdata[met_pkg::ITER_W-1:0];
				met_pkg::CFG_PIXEL_SCALE:    scale_q  <= cfg_wdata[met_pkg::SCALE_W-1:0];
				met_pkg::CFG_CENTER_REAL:    cre_q    <= cfg_wdata;
				met_pkg::CFG_CENTER_IMAG:    cim_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q   <= column;
			row_q   <= row_index;
			zr_q    <= '0;
			zi_q    <= '0;
			count_q <= '0;
		end
		if (cmd.wr_cr) begin
			cr_q <= met_pkg::sat_add(mres, cre_q);
		end
		if (cmd.wr_ci) begin
			ci_q <= met_pkg::sat_add(mres, cim_q);
		end
		if (cmd.wr_rr) begin
			rr_q <= mres;
		end
		if (cmd.wr_ii) begin
			esc_q  <= (met_pkg::sat_add(rr_q, mres) >= FOUR);
			diff_q <= met_pkg::sat_sub(rr_q, mres);
		end
		if (cmd.wr_z) begin
			zr_q    <= met_pkg::sat_add(diff_q, cr_q);
			zi_q    <= met_pkg::sat_add(mres, ci_q);
			count_q <= count_q + 1'b1;
		end
		if (cmd.out_load) begin
			// zero limit: the divider would see a zero divisor
			intensity_q <= (max_q == '0) ? '0 : div_quo;
			iter_out_q  <= count_q;
		end
	end

	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign status.cnt_lim  = (count_q >= max_q);
	assign status.esc      = esc_q;

	assign intensity       = intensity_q;
	assign iteration_count = iter_out_q;

endmodule

// ===== rtl/core/met_ctrl.sv =====
`timescale 1ns / 1ps

module met_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  met_pkg::met_status_t  status,
	output met_pkg::met_cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MRE   = 4'd1;
	localparam logic [3:0] ST_MRE_W = 4'd2;
	localparam logic [3:0] ST_MIM   = 4'd3;
	localparam logic [3:0] ST_MIM_W = 4'd4;
	localparam logic [3:0] ST_TEST  = 4'd5;
	localparam logic [3:0] ST_RR    = 4'd6;
	localparam logic [3:0] ST_RR_W  = 4'd7;
	localparam logic [3:0] ST_II    = 4'd8;
	localparam logic [3:0] ST_II_W  = 4'd9;
	localparam logic [3:0] ST_ESC   = 4'd10;
	localparam logic [3:0] ST_RI    = 4'd11;
	localparam logic [3:0] ST_RI_W  = 4'd12;
	localparam logic [3:0] ST_DIV   = 4'd13;
	localparam logic [3:0] ST_DIV_W = 4'd14;
	localparam logic [3:0] ST_FIN   = 4'd15;

	logic [3:0] state_q, state_d;
	logic       out_vld_q;
	logic       out_free;

	// output register can take a new beat when empty or draining now
	assign out_free = !out_vld_q || result_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_op = met_pkg::MOP_RR;
		case (state_q)
			ST_IDLE: begin
				if (pixel_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MRE;
				end
			end
			ST_MRE: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = met_pkg::MOP_MAP_RE;
				state_d       = ST_MRE_W;
			end
			ST_MRE_W: begin
				if (status.mul_done) begin
					cmd.wr_cr = 1'b1;
					state_d   = ST_MIM;
				end
			end
			ST_MIM: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = met_pkg::MOP_MAP_IM;
				state_d       = ST_MIM_W;
			end
			ST_MIM_W: begin
				if (status.mul_done) begin
					cmd.wr_ci = 1'b1;
					state_d   = ST_TEST;
				end
			end
			ST_TEST: begin
				state_d = status.cnt_lim ? ST_DIV : ST_RR;
			end
			ST_RR: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = met_pkg::MOP_RR;
				state_d       = ST_RR_W;
			end
			ST_RR_W: begin
				if (status.mul_done) begin
					cmd.wr_rr = 1'b1;
					state_d   = ST_II;
				end
			end
			ST_II: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = met_pkg::MOP_II;
				state_d       = ST_II_W;
			end
			ST_II_W: begin
				if (status.mul_done) begin
					cmd.wr_ii = 1'b1;
					state_d   = ST_ESC;
				end
			end
			ST_ESC: begin
				state_d = status.esc ? ST_DIV : ST_RI;
			end
			ST_RI: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = met_pkg::MOP_RI;
				state_d       = ST_RI_W;
			end
			ST_RI_W: begin
				if (status.mul_done) begin
					cmd.wr_z = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_W;
			end
			ST_DIV_W: begin
				if (status.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign pixel_ready  = (state_q == ST_IDLE);
	assign result_valid = out_vld_q;

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Beat fields                     Handshake
// pixel    in   column, row_index               valid/ready
// result   out  intensity, iteration_count      valid/ready
// cfg      in   cfg_index, cfg_wdata            cfg_we, no back-pressure
//
// The loop runs until the iteration limit ends it or the point escapes. Each full
// iteration is three 64x64 products on the single shared 32x32 multiplier (four partial
// products, accumulate, shift/saturate for each); the intensity divide follows the loop.
// Reset clears control and loads the register defaults; nothing to sweep.
// A new pixel is taken as soon as the previous one is parked in the output
// register; a stalled result only holds up the next finished pixel.
module mandelbrot_escape_time_pixel #(
	parameter int unsigned MAX_DIM   = 4096,
	parameter int unsigned FRAC_BITS = 56
) (
	input  logic                             clk,
	input  logic                             arst_n,
	met_pixel_if.sink                        pixel,
	met_result_if.source                     result,
	input  logic                             cfg_we,
	input  logic [met_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [met_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	met_pkg::met_cmd_t    cmd;
	met_pkg::met_status_t status;

	met_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel.valid),
		.pixel_ready  (pixel.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	met_datapath #(
		.MAX_DIM   (MAX_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.column          (pixel.column),
		.row_index       (pixel.row_index),
		.cmd             (cmd),
		.status          (status),
		.intensity       (result.intensity),
		.iteration_count (result.iteration_count)
	);

endmodule
